/* hw/rtl/ppp_pkg.sv */
// shared constants and types for the pinhole point projection block
// no dependencies; imported by the interfaces and all modules
`timescale 1ns / 1ps
`default_nettype none

package ppp_pkg;

	// coordinate and register widths
	localparam int COORD_W = 32;
	localparam int IDX_W   = 16;
	localparam int ROT_W   = 18;
	localparam int ROT_FRAC = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = ROT_W + DIFF_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int FP_W    = 2 * COORD_W;

	// parameter defaults
	localparam int INDEX_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;

	// divider layout: quotient magnitude bits below the saturation point
	localparam int QBITS      = 33;
	localparam int DIV_STEPS  = 3;
	localparam int DIV_STAGES = QBITS / DIV_STEPS;
	localparam int DIV_LAT    = DIV_STAGES + 1;
	localparam int NUM_W      = FP_W - 1;
	localparam int DEN_W      = COORD_W;
	localparam int QS_W       = QBITS + 2;

	// configuration port
	localparam int APB_AW = 6;
	localparam int APB_DW = 64;

	typedef enum logic [2:0] {
		REG_ROT0   = 3'd0,
		REG_ROT1   = 3'd1,
		REG_ROT2   = 3'd2,
		REG_POS_XY = 3'd3,
		REG_POS_Z  = 3'd4,
		REG_FOCAL  = 3'd5,
		REG_PP     = 3'd6,
		REG_SIZE   = 3'd7
	} reg_idx_t;

	localparam logic [3*ROT_W-1:0] ROT0_RST = 54'h10_0000_0000_0000;
	localparam logic [3*ROT_W-1:0] ROT1_RST = 54'h00_0004_0000_0000;
	localparam logic [3*ROT_W-1:0] ROT2_RST = 54'h00_0000_0001_0000;

endpackage

`default_nettype wire

/* hw/rtl/ppp_if.sv */
// valid/ready channel interfaces for points in and projections out
// depends on ppp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ppp_pt_if import ppp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] world_x;
	logic signed [COORD_W-1:0] world_y;
	logic signed [COORD_W-1:0] world_z;
	logic [IDX_W-1:0]          point_index;

	modport source(output valid, world_x, world_y, world_z, point_index, input ready);
	modport sink(input valid, world_x, world_y, world_z, point_index, output ready);
endinterface

interface ppp_proj_if import ppp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] u_coord;
	logic signed [COORD_W-1:0] v_coord;
	logic                      visible;
	logic                      zero_depth;
	logic [IDX_W-1:0]          index_out;

	modport source(output valid, u_coord, v_coord, visible, zero_depth, index_out,
		input ready);
	modport sink(input valid, u_coord, v_coord, visible, zero_depth, index_out,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/ppp_div.sv */
// pipelined signed divider, quotient truncated toward zero and clamped
// depends on ppp_pkg; one restoring step per quotient bit, DIV_STEPS per stage
`timescale 1ns / 1ps
`default_nettype none

module ppp_div import ppp_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [FP_W-1:0]  num,
	input  wire logic signed [DEN_W-1:0] den,
	output logic signed [QS_W-1:0]       quo
);

	// operand magnitudes and overflow test
	logic [NUM_W-1:0] nmag;
	logic [DEN_W-1:0] dmag;
	logic             ovf;

	assign nmag = num[FP_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign dmag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
	assign ovf  = {2'b00, nmag} >= {dmag, {QBITS{1'b0}}};

	logic [DEN_W-1:0] rem_s [DIV_LAT];
	logic [QBITS-1:0] nlo_s [DIV_LAT];
	logic [QBITS-1:0] q_s   [DIV_LAT];
	logic [DEN_W-1:0] den_s [DIV_LAT];
	logic             neg_s [DIV_LAT];
	logic             ovf_s [DIV_LAT];

	// entry stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DEN_W'(nmag[NUM_W-1:QBITS]);
			nlo_s[0] <= nmag[QBITS-1:0];
			q_s[0]   <= '0;
			den_s[0] <= dmag;
			neg_s[0] <= num[FP_W-1] ^ den[DEN_W-1];
			ovf_s[0] <= ovf;
		end
	end

	// restoring steps
	for (genvar g = 1; g < DIV_LAT; g++) begin : g_stage
		logic [DEN_W-1:0] rem_n;
		logic [QBITS-1:0] nlo_n;
		logic [QBITS-1:0] q_n;

		always_comb begin
			logic [DEN_W:0] t;
			rem_n = rem_s[g-1];
			nlo_n = nlo_s[g-1];
			q_n   = q_s[g-1];
			for (int k = 0; k < DIV_STEPS; k++) begin
				t = {rem_n, nlo_n[QBITS-1]};
				nlo_n = {nlo_n[QBITS-2:0], 1'b0};
				if (t >= {1'b0, den_s[g-1]}) begin
					rem_n = DEN_W'(t - {1'b0, den_s[g-1]});
					q_n   = {q_n[QBITS-2:0], 1'b1};
				end else begin
					rem_n = t[DEN_W-1:0];
					q_n   = {q_n[QBITS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_n;
				nlo_s[g] <= nlo_n;
				q_s[g]   <= q_n;
				den_s[g] <= den_s[g-1];
				neg_s[g] <= neg_s[g-1];
				ovf_s[g] <= ovf_s[g-1];
			end
		end
	end

	// signed quotient, clamped to plus or minus 2^QBITS on overflow
	logic [QS_W-1:0] qmag;
	assign qmag = ovf_s[DIV_LAT-1] ? (QS_W'(1) << QBITS) : QS_W'(q_s[DIV_LAT-1]);
	assign quo  = neg_s[DIV_LAT-1] ? $signed(-qmag) : $signed(qmag);

endmodule

`default_nettype wire

/* hw/rtl/pinhole_point_projection_top.sv */
// pinhole projection: rigid transform, projection divide, visibility test
// depends on ppp_pkg, ppp_if and ppp_div
// throughput: one point per cycle; the whole pipeline holds while the output stalls
// the rate is set by the pipelined 33-step divider, three steps per stage
// reset: asynchronous, clears valid bits and loads the identity pose, zero intrinsics
`timescale 1ns / 1ps
`default_nettype none

module pinhole_point_projection_top import ppp_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	ppp_pt_if.sink                 pt_in,
	ppp_proj_if.source             pt_out,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	localparam int IW = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
	localparam int LW = (IDX_W + FRAC_BITS > COORD_W) ? IDX_W + FRAC_BITS : COORD_W;

	// configuration registers
	logic [3*ROT_W-1:0] rot_q [3];
	logic [FP_W-1:0]    pos_xy_q;
	logic [COORD_W-1:0] pos_z_q;
	logic [FP_W-1:0]    focal_q;
	logic [FP_W-1:0]    pp_q;
	logic [COORD_W-1:0] size_q;
	reg_idx_t           widx;

	assign widx   = reg_idx_t'(paddr[5:3]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= ROT0_RST;
			rot_q[1] <= ROT1_RST;
			rot_q[2] <= ROT2_RST;
			pos_xy_q <= '0;
			pos_z_q  <= '0;
			focal_q  <= '0;
			pp_q     <= '0;
			size_q   <= '0;
		end else if (psel && penable && pwrite) begin
			case (widx)
				REG_ROT0:   rot_q[0] <= pwdata[3*ROT_W-1:0];
				REG_ROT1:   rot_q[1] <= pwdata[3*ROT_W-1:0];
				REG_ROT2:   rot_q[2] <= pwdata[3*ROT_W-1:0];
				REG_POS_XY: pos_xy_q <= pwdata;
				REG_POS_Z:  pos_z_q  <= pwdata[COORD_W-1:0];
				REG_FOCAL:  focal_q  <= pwdata;
				REG_PP:     pp_q     <= pwdata;
				REG_SIZE:   size_q   <= pwdata[COORD_W-1:0];
				default:    ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (widx)
			REG_ROT0:   prdata = APB_DW'(rot_q[0]);
			REG_ROT1:   prdata = APB_DW'(rot_q[1]);
			REG_ROT2:   prdata = APB_DW'(rot_q[2]);
			REG_POS_XY: prdata = pos_xy_q;
			REG_POS_Z:  prdata = APB_DW'(pos_z_q);
			REG_FOCAL:  prdata = focal_q;
			REG_PP:     prdata = pp_q;
			REG_SIZE:   prdata = APB_DW'(size_q);
			default:    prdata = '0;
		endcase
	end

	// pipeline advance: every stage moves together unless the output beat stalls
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_d [DIV_LAT];

	assign adv         = !vld_s6 || pt_out.ready;
	assign pt_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) vld_d[i] <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pt_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_d[0] <= vld_s4;
			for (int i = 1; i < DIV_LAT; i++) vld_d[i] <= vld_d[i-1];
			vld_s5 <= vld_d[DIV_LAT-1];
			vld_s6 <= vld_s5;
		end
	end

	// stage 1: offset from camera position
	logic signed [DIFF_W-1:0] d_s1 [3];
	logic [IW-1:0]            idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0] <= DIFF_W'(pt_in.world_x) - DIFF_W'($signed(pos_xy_q[FP_W-1:COORD_W]));
			d_s1[1] <= DIFF_W'(pt_in.world_y) - DIFF_W'($signed(pos_xy_q[COORD_W-1:0]));
			d_s1[2] <= DIFF_W'(pt_in.world_z) - DIFF_W'($signed(pos_z_q));
			idx_s1  <= pt_in.point_index[IW-1:0];
		end
	end

	// stage 2: rotation products, entry R[k][j] times offset k
	logic signed [PROD_W-1:0] prod_s2 [3][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s2[j][k] <= PROD_W'($signed(rot_q[k][(2-j)*ROT_W +: ROT_W]))
						* PROD_W'(d_s1[k]);
				end
			end
			idx_s2 <= idx_s1;
		end
	end

	// stage 3: sum, floor by the rotation fraction, saturate to camera coordinates
	logic signed [COORD_W-1:0] cam_s3 [3];

	always_ff @(posedge clk) begin
		logic signed [ACC_W-1:0]          acc;
		logic signed [ACC_W-ROT_FRAC-1:0] fl;
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				acc = ACC_W'(prod_s2[j][0]) + ACC_W'(prod_s2[j][1]) + ACC_W'(prod_s2[j][2]);
				fl  = acc[ACC_W-1:ROT_FRAC];
				if (fl > (ACC_W-ROT_FRAC)'(32'sh7FFF_FFFF))
					cam_s3[j] <= 32'sh7FFF_FFFF;
				else if (fl < -(ACC_W-ROT_FRAC)'(33'sh0_8000_0000))
					cam_s3[j] <= 32'sh8000_0000;
				else
					cam_s3[j] <= fl[COORD_W-1:0];
			end
			idx_s3 <= idx_s2;
		end
	end

	// stage 4: focal products
	logic signed [FP_W-1:0]    px_s4, py_s4;
	logic signed [COORD_W-1:0] z_s4;
	logic                      zz_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s4  <= FP_W'($signed(focal_q[FP_W-1:COORD_W])) * FP_W'(cam_s3[0]);
			py_s4  <= FP_W'($signed(focal_q[COORD_W-1:0])) * FP_W'(cam_s3[1]);
			z_s4   <= cam_s3[2];
			zz_s4  <= cam_s3[2] == '0;
			idx_s4 <= idx_s3;
		end
	end

	// projection divides
	logic signed [QS_W-1:0] qu, qv;

	ppp_div u_div_u (.clk(clk), .en(adv), .num(px_s4), .den(z_s4), .quo(qu));
	ppp_div u_div_v (.clk(clk), .en(adv), .num(py_s4), .den(z_s4), .quo(qv));

	// side line matching the divider latency
	logic          zz_d  [DIV_LAT];
	logic [IW-1:0] idx_d [DIV_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			zz_d[0]  <= zz_s4;
			idx_d[0] <= idx_s4;
			for (int i = 1; i < DIV_LAT; i++) begin
				zz_d[i]  <= zz_d[i-1];
				idx_d[i] <= idx_d[i-1];
			end
		end
	end

	// stage 5: add principal point and saturate, or zero both coordinates at zero depth
	function automatic logic signed [COORD_W-1:0] add_sat(
		input logic signed [QS_W-1:0]    q,
		input logic signed [COORD_W-1:0] c
	);
		logic signed [QS_W:0] s;
		s = (QS_W+1)'(q) + (QS_W+1)'(c);
		if (s > (QS_W+1)'(32'sh7FFF_FFFF))
			return 32'sh7FFF_FFFF;
		else if (s < -(QS_W+1)'(33'sh0_8000_0000))
			return 32'sh8000_0000;
		else
			return s[COORD_W-1:0];
	endfunction

	logic signed [COORD_W-1:0] u_s5, v_s5;
	logic                      zz_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s5   <= zz_d[DIV_LAT-1] ? '0 : add_sat(qu, $signed(pp_q[FP_W-1:COORD_W]));
			v_s5   <= zz_d[DIV_LAT-1] ? '0 : add_sat(qv, $signed(pp_q[COORD_W-1:0]));
			zz_s5  <= zz_d[DIV_LAT-1];
			idx_s5 <= idx_d[DIV_LAT-1];
		end
	end

	// stage 6: bounds test, output register
	logic signed [COORD_W-1:0] u_s6, v_s6;
	logic                      zz_s6, vis_s6;
	logic [LW-1:0]             wl, hl;

	assign wl = LW'(size_q[COORD_W-1:IDX_W]) << FRAC_BITS;
	assign hl = LW'(size_q[IDX_W-1:0]) << FRAC_BITS;

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s6   <= u_s5;
			v_s6   <= v_s5;
			zz_s6  <= zz_s5;
			vis_s6 <= !zz_s5 && !u_s5[COORD_W-1] && !v_s5[COORD_W-1]
				&& (LW'(unsigned'(u_s5)) < wl) && (LW'(unsigned'(v_s5)) < hl);
			idx_s6 <= idx_s5;
		end
	end

	assign pt_out.valid      = vld_s6;
	assign pt_out.u_coord    = u_s6;
	assign pt_out.v_coord    = v_s6;
	assign pt_out.visible    = vis_s6;
	assign pt_out.zero_depth = zz_s6;
	assign pt_out.index_out  = IDX_W'(idx_s6);

endmodule

`default_nettype wire

/* bench/pinhole_point_projection_top_tb.sv */
// self-checking bench for the pinhole point projection block
// depends on ppp_pkg, ppp_if and the rtl of pinhole_point_projection_top
// random stalls on both sides, register phases from identity through extremes to zero rotation
`timescale 1ns / 1ps
`default_nettype none

module pinhole_point_projection_top_tb;
	import ppp_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [15:0]        idx;
	} point_t;

	typedef struct packed {
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic               vis;
		logic               zd;
		logic [15:0]        idx;
	} proj_t;

	// one stimulus row; typed rows carry their own expected projection
	typedef struct packed {
		point_t pt;
		logic   typed;
		proj_t  want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	ppp_pt_if pt_in_if();
	ppp_proj_if pt_out_if();

	pinhole_point_projection_top uut (
		.clk(clk), .arst_n(arst_n), .pt_in(pt_in_if), .pt_out(pt_out_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// shadow copy of the camera registers
	logic [63:0] cam_regs [8];
	row_t launched_q [$];
	proj_t pending_proj_q [$];
	int mismatches = 0, points_sent = 0, projections_seen = 0, visible_seen = 0;
	int zero_depth_seen = 0, idle_cycles = 0;
	bit quiet = 1'b0;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// camera-frame transform, divide and bounds test
	function automatic proj_t project_point(point_t p);
		longint d [3];
		longint cam [3];
		longint acc, r, q, wl, hl, u, v;
		proj_t o;
		d[0] = longint'(p.x) - longint'($signed(cam_regs[REG_POS_XY][63:32]));
		d[1] = longint'(p.y) - longint'($signed(cam_regs[REG_POS_XY][31:0]));
		d[2] = longint'(p.z) - longint'($signed(cam_regs[REG_POS_Z][31:0]));
		for (int j = 0; j < 3; j++) begin
			acc = 0;
			for (int k = 0; k < 3; k++) begin
				r = longint'($signed(cam_regs[k][(2-j)*ROT_W +: ROT_W]));
				acc += r * d[k];
			end
			cam[j] = clamp32(acc >>> ROT_FRAC);
		end
		o = '0;
		o.idx = p.idx;
		if (cam[2] == 0) begin
			o.zd = 1'b1;
		end else begin
			q = (longint'($signed(cam_regs[REG_FOCAL][63:32])) * cam[0]) / cam[2];
			u = clamp32(q + longint'($signed(cam_regs[REG_PP][63:32])));
			q = (longint'($signed(cam_regs[REG_FOCAL][31:0])) * cam[1]) / cam[2];
			v = clamp32(q + longint'($signed(cam_regs[REG_PP][31:0])));
			wl = longint'(cam_regs[REG_SIZE][31:16]) << 16;
			hl = longint'(cam_regs[REG_SIZE][15:0]) << 16;
			o.u = u[31:0];
			o.v = v[31:0];
			o.vis = (u >= 0) && (u < wl) && (v >= 0) && (v < hl);
		end
		return o;
	endfunction

	// input beats: queue the expected projection
	always @(posedge clk) begin
		row_t launched;
		if (pt_in_if.valid && pt_in_if.ready) begin
			launched = launched_q.pop_front();
			pending_proj_q.push_back(launched.typed ? launched.want
				: project_point(launched.pt));
		end
	end

	// output beats: compare against the oldest expectation
	always @(posedge clk) begin
		proj_t got, want;
		if (pt_out_if.valid && pt_out_if.ready) begin
			got = '{pt_out_if.u_coord, pt_out_if.v_coord, pt_out_if.visible,
				pt_out_if.zero_depth, pt_out_if.index_out};
			projections_seen++;
			visible_seen += got.vis;
			zero_depth_seen += got.zd;
			if (pending_proj_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: u=%h v=%h idx=%h", got.u, got.v, got.idx);
			end else begin
				want = pending_proj_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch idx %h: expected u=%h v=%h vis=%b zd=%b idx=%h,",
							" got u=%h v=%h vis=%b zd=%b idx=%h"},
							want.idx, want.u, want.v, want.vis, want.zd, want.idx,
							got.u, got.v, got.vis, got.zd, got.idx);
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((pt_in_if.valid && pt_in_if.ready) || (pt_out_if.valid && pt_out_if.ready)
				|| (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// output side stalls
	initial begin
		int gap;
		pt_out_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				pt_out_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pt_out_if.ready <= 1'b1;
			do @(posedge clk); while (!pt_out_if.valid);
		end
	end

	task automatic write_reg(reg_idx_t r, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({r, 3'b000});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_ROT0, REG_ROT1, REG_ROT2: cam_regs[r] = val & 64'h003F_FFFF_FFFF_FFFF;
			REG_POS_Z, REG_SIZE:          cam_regs[r] = val & 64'h0000_0000_FFFF_FFFF;
			default:                      cam_regs[r] = val;
		endcase
	endtask

	// drop valid after the last beat, then let the pipeline drain
	task automatic wait_idle();
		pt_in_if.valid <= 1'b0;
		while (pending_proj_q.size() != 0 || launched_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_point(row_t row);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			pt_in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		launched_q.push_back(row);
		pt_in_if.valid <= 1'b1;
		pt_in_if.world_x <= row.pt.x;
		pt_in_if.world_y <= row.pt.y;
		pt_in_if.world_z <= row.pt.z;
		pt_in_if.point_index <= row.pt.idx;
		do @(posedge clk); while (!pt_in_if.ready);
		points_sent++;
	endtask

	function automatic row_t any_point();
		row_t r;
		r = '0;
		r.pt = '{$urandom(), $urandom(), $urandom(), 16'($urandom())};
		return r;
	endfunction

	// point in front of a 640x480 camera, mostly inside the frustum
	function automatic row_t scene_point();
		row_t r;
		int zi, span;
		r = '0;
		zi = $urandom_range(1, 30);
		span = zi * 45000;
		r.pt.z = (zi << 16) + $urandom_range(0, 65535);
		r.pt.x = $urandom_range(0, 2 * span) - span;
		r.pt.y = $urandom_range(0, 2 * span) - span;
		r.pt.idx = 16'($urandom());
		return r;
	endfunction

	function automatic row_t fixed_row(int x, int y, int z, logic [15:0] idx);
		row_t r;
		r = '0;
		r.pt = '{x, y, z, idx};
		return r;
	endfunction

	// reset pose with zero intrinsics: u and v are zero, zero depth where z is zero
	function automatic row_t reset_row(int x, int y, int z, logic [15:0] idx);
		row_t r;
		r = fixed_row(x, y, z, idx);
		r.typed = 1'b1;
		r.want = '{32'sd0, 32'sd0, 1'b0, z == 0, idx};
		return r;
	endfunction

	initial begin
		row_t reset_rows [6];
		row_t scene_rows [12];
		pt_in_if.valid = 1'b0;
		pt_in_if.world_x = '0;
		pt_in_if.world_y = '0;
		pt_in_if.world_z = '0;
		pt_in_if.point_index = '0;
		cam_regs[REG_ROT0] = 64'(ROT0_RST);
		cam_regs[REG_ROT1] = 64'(ROT1_RST);
		cam_regs[REG_ROT2] = 64'(ROT2_RST);
		for (int i = 3; i < 8; i++) cam_regs[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset pose, zero depth and extremes
		reset_rows = '{
			reset_row(0, 0, 0, 16'hFFFF),
			reset_row(32'h7FFFFFFF, 32'h80000000, 32'h00010000, 16'h0000),
			reset_row(32'h80000000, 32'h7FFFFFFF, -1, 16'h5A5A),
			reset_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hA5A5),
			reset_row(32'h80000000, 32'h80000000, 32'h80000000, 16'h0001),
			reset_row(123456, -98765, 0, 16'h8000)
		};
		foreach (reset_rows[i]) send_point(reset_rows[i]);
		wait_idle();

		// typical camera, 640x480
		write_reg(REG_FOCAL, {32'(500 << 16), 32'(500 << 16)});
		write_reg(REG_PP, {32'(320 << 16), 32'(240 << 16)});
		write_reg(REG_SIZE, {16'd640, 16'd480});
		write_reg(REG_POS_XY, {32'(-1 << 16), 32'(2 << 16)});
		write_reg(REG_POS_Z, 64'(32'(-5 << 16)));
		scene_rows = '{
			fixed_row(-1 << 16, 2 << 16, 0, 16'h0010),
			fixed_row(-1 << 16, 2 << 16, 1 << 16, 16'h0011),
			fixed_row(-1 << 16, 2 << 16, -4 << 16, 16'h0012),
			fixed_row(-1 << 16, 2 << 16, -6 << 16, 16'h0013),
			fixed_row(32'h7FFFFFFF, 0, -5 << 16 | 1, 16'h0014),
			fixed_row(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0015),
			fixed_row(0, 0, 32'h80000000, 16'h0016),
			fixed_row(-(1 << 16) - 1, 2 << 16, -5 << 16 + 1, 16'h0017),
			fixed_row(-(1 << 16) + (640 << 14), 2 << 16, -3 << 16, 16'h0018),
			fixed_row(-(1 << 16) - (640 << 14), -(240 << 14), -3 << 16, 16'h0019),
			fixed_row(7, -7, -(5 << 16) + 2, 16'h001A),
			fixed_row(32'h7FFFFFFF, 32'h7FFFFFFF, -(5 << 16) + 1, 16'h001B)
		};
		foreach (scene_rows[i]) send_point(scene_rows[i]);
		wait_idle();
		write_reg(REG_POS_XY, 64'd0);
		write_reg(REG_POS_Z, 64'd0);
		quiet = 1'b1;
		for (int i = 0; i < 60; i++) send_point(scene_point());
		quiet = 1'b0;
		for (int i = 0; i < 90; i++)
			send_point(($urandom_range(0, 9) == 0) ? any_point() : scene_point());
		wait_idle();

		// random pose and intrinsics, bits above each register width set
		for (int r = 0; r < 8; r++)
			write_reg(reg_idx_t'(r), {$urandom(), $urandom()});
		for (int i = 0; i < 180; i++) send_point(any_point());
		wait_idle();

		// extreme registers
		write_reg(REG_ROT0, {18'h20000, 18'h1FFFF, 18'h3FFFF});
		write_reg(REG_ROT1, {18'h1FFFF, 18'h20000, 18'h00001});
		write_reg(REG_ROT2, {18'h3FFFF, 18'h1FFFF, 18'h20000});
		write_reg(REG_POS_XY, {32'h80000000, 32'h7FFFFFFF});
		write_reg(REG_POS_Z, 64'h0000_0000_8000_0000);
		write_reg(REG_FOCAL, {32'h7FFFFFFF, 32'h80000000});
		write_reg(REG_PP, {32'h80000000, 32'h7FFFFFFF});
		write_reg(REG_SIZE, 64'hFFFF_FFFF);
		for (int i = 0; i < 75; i++) send_point(any_point());
		wait_idle();

		// zero rotation: depth always zero
		write_reg(REG_ROT0, 64'd0);
		write_reg(REG_ROT1, 64'd0);
		write_reg(REG_ROT2, 64'd0);
		quiet = 1'b1;
		for (int i = 0; i < 25; i++) send_point(any_point());
		wait_idle();

		$display("%0d points sent, %0d projections checked (%0d visible, %0d zero depth)",
			points_sent, projections_seen, visible_seen, zero_depth_seen);
		$display("register phases: reset pose, typical camera, random, extremes, zero rotation");
		if (mismatches == 0 && pending_proj_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
